// ----- hw/rtl/keypad_code_lock_assert.svh -----
// Assertion macros for the keypad code lock RTL; kcl_core includes them.
`ifndef KEYPAD_CODE_LOCK_ASSERT_SVH
`define KEYPAD_CODE_LOCK_ASSERT_SVH

// Same-cycle implication, checked on clk and disabled during rst.
`define KCL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on clk and disabled during rst.
`define KCL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/kcl_pkg.sv -----
// Shared constants, codes and types of the keypad code lock.
package kcl_pkg;

  localparam int CODE_LEN = 4;
  localparam int PACK_W   = 4 * CODE_LEN;
  localparam int CMP_W    = (PACK_W > 16) ? PACK_W : 16;
  localparam int CNT_W    = $clog2(CODE_LEN + 1);
  localparam int IDX_W    = (CODE_LEN > 1) ? $clog2(CODE_LEN) : 1;
  localparam int ADDR_W   = 5;

  localparam logic [3:0] KEY_STAR = 4'd14;
  localparam logic [3:0] KEY_HASH = 4'd15;

  localparam logic [2:0] EV_NONE     = 3'd0;
  localparam logic [2:0] EV_STORED   = 3'd1;
  localparam logic [2:0] EV_CLEARED  = 3'd2;
  localparam logic [2:0] EV_GRANTED  = 3'd3;
  localparam logic [2:0] EV_ADMIN    = 3'd4;
  localparam logic [2:0] EV_INVALID  = 3'd5;
  localparam logic [2:0] EV_RELOCKED = 3'd6;

  localparam logic [2:0] UID_NONE   = 3'd0;
  localparam logic [2:0] UID_USER_A = 3'd1;
  localparam logic [2:0] UID_USER_B = 3'd2;
  localparam logic [2:0] UID_USER_C = 3'd3;
  localparam logic [2:0] UID_ADMIN  = 3'd4;

  localparam logic [2:0] REG_USER_A       = 3'd0;
  localparam logic [2:0] REG_USER_B       = 3'd1;
  localparam logic [2:0] REG_USER_C       = 3'd2;
  localparam logic [2:0] REG_ADMIN        = 3'd3;
  localparam logic [2:0] REG_UNLOCK_TICKS = 3'd4;
  localparam logic [2:0] REG_INVALID_HOLD = 3'd5;
  localparam logic [2:0] REG_ADMIN_HOLD   = 3'd6;

  localparam logic [15:0] RST_USER_A       = 16'h1234;
  localparam logic [15:0] RST_USER_B       = 16'h4321;
  localparam logic [15:0] RST_USER_C       = 16'h5678;
  localparam logic [15:0] RST_ADMIN        = 16'h0000;
  localparam logic [15:0] RST_UNLOCK_TICKS = 16'd5000;
  localparam logic [15:0] RST_INVALID_HOLD = 16'd3000;
  localparam logic [15:0] RST_ADMIN_HOLD   = 16'd5000;

  typedef struct packed {
    logic [15:0] code_user_a;
    logic [15:0] code_user_b;
    logic [15:0] code_user_c;
    logic [15:0] code_admin;
    logic [15:0] unlock_ticks;
    logic [15:0] invalid_hold_ticks;
    logic [15:0] admin_hold_ticks;
  } kcl_cfg_t;

  typedef struct packed {
    logic       lock_open;
    logic [2:0] event_res;
    logic [2:0] user_id;
    logic [2:0] entered_count;
    logic       holding;
  } kcl_res_t;

endpackage

// ----- hw/rtl/kcl_regs.sv -----
// Configuration register file behind the APB-style port.
module kcl_regs (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [kcl_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output kcl_pkg::kcl_cfg_t         cfg
);
  import kcl_pkg::*;

  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.code_user_a        <= RST_USER_A;
      cfg.code_user_b        <= RST_USER_B;
      cfg.code_user_c        <= RST_USER_C;
      cfg.code_admin         <= RST_ADMIN;
      cfg.unlock_ticks       <= RST_UNLOCK_TICKS;
      cfg.invalid_hold_ticks <= RST_INVALID_HOLD;
      cfg.admin_hold_ticks   <= RST_ADMIN_HOLD;
    end else if (wr_en) begin
      case (reg_idx)
        REG_USER_A:       cfg.code_user_a        <= pwdata[15:0];
        REG_USER_B:       cfg.code_user_b        <= pwdata[15:0];
        REG_USER_C:       cfg.code_user_c        <= pwdata[15:0];
        REG_ADMIN:        cfg.code_admin         <= pwdata[15:0];
        REG_UNLOCK_TICKS: cfg.unlock_ticks       <= pwdata[15:0];
        REG_INVALID_HOLD: cfg.invalid_hold_ticks <= pwdata[15:0];
        REG_ADMIN_HOLD:   cfg.admin_hold_ticks   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_USER_A:       prdata = {16'd0, cfg.code_user_a};
      REG_USER_B:       prdata = {16'd0, cfg.code_user_b};
      REG_USER_C:       prdata = {16'd0, cfg.code_user_c};
      REG_ADMIN:        prdata = {16'd0, cfg.code_admin};
      REG_UNLOCK_TICKS: prdata = {16'd0, cfg.unlock_ticks};
      REG_INVALID_HOLD: prdata = {16'd0, cfg.invalid_hold_ticks};
      REG_ADMIN_HOLD:   prdata = {16'd0, cfg.admin_hold_ticks};
      default:          prdata = 32'd0;
    endcase
  end

endmodule

// ----- hw/rtl/kcl_core.sv -----
// Lock state, entry buffer, timers and the per-beat update logic.
`include "keypad_code_lock_assert.svh"

module kcl_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic              action,
  input  logic [3:0]        key_code,
  input  kcl_pkg::kcl_cfg_t cfg,
  output kcl_pkg::kcl_res_t res
);
  import kcl_pkg::*;

  logic [3:0]       entry_keys [CODE_LEN];
  logic [CNT_W-1:0] entry_count;
  logic             lock_state;
  logic [15:0]      open_timer;
  logic [15:0]      hold_timer;

  logic [CNT_W-1:0] entry_count_next;
  logic             lock_state_next;
  logic [15:0]      open_timer_next;
  logic [15:0]      hold_timer_next;
  logic             key_we;

  logic [PACK_W-1:0] packed_entry;
  logic [CMP_W-1:0]  entry_ext;
  logic [CNT_W-1:0]  count_inc;
  logic              is_star;
  logic [2:0]        ev;
  logic [2:0]        uid;

  // The key of this beat takes its slot directly, so a full entry compares in one pass.
  always_comb begin
    for (int i = 0; i < CODE_LEN; i++) begin
      packed_entry[PACK_W-1-4*i -: 4] =
        (CNT_W'(i) == entry_count) ? key_code : entry_keys[i];
    end
  end

  assign entry_ext = CMP_W'(packed_entry);
  assign count_inc = entry_count + CNT_W'(1);
  assign is_star   = (key_code == KEY_STAR);

  always_comb begin
    entry_count_next = entry_count;
    lock_state_next  = lock_state;
    open_timer_next  = open_timer;
    hold_timer_next  = hold_timer;
    key_we           = 1'b0;
    ev               = EV_NONE;
    uid              = UID_NONE;
    if (!action) begin
      if (hold_timer != 16'd0) begin
        hold_timer_next = hold_timer - 16'd1;
      end
      if (lock_state) begin
        if (open_timer <= 16'd1) begin
          open_timer_next  = 16'd0;
          lock_state_next  = 1'b0;
          entry_count_next = '0;
          ev               = EV_RELOCKED;
        end else begin
          open_timer_next = open_timer - 16'd1;
        end
      end
    end else if (hold_timer != 16'd0) begin
      ev = EV_NONE;
    end else if (key_code == KEY_HASH) begin
      entry_count_next = '0;
      ev               = EV_CLEARED;
    end else begin
      key_we           = 1'b1;
      entry_count_next = count_inc;
      ev               = EV_STORED;
      if (count_inc >= CNT_W'(CODE_LEN) || is_star) begin
        if (!is_star && entry_ext == CMP_W'(cfg.code_user_a)) begin
          uid = UID_USER_A;
        end else if (!is_star && entry_ext == CMP_W'(cfg.code_user_b)) begin
          uid = UID_USER_B;
        end else if (!is_star && entry_ext == CMP_W'(cfg.code_user_c)) begin
          uid = UID_USER_C;
        end else if (!is_star && entry_ext == CMP_W'(cfg.code_admin)) begin
          uid = UID_ADMIN;
        end
        if (uid == UID_USER_A || uid == UID_USER_B || uid == UID_USER_C) begin
          lock_state_next = 1'b1;
          open_timer_next = cfg.unlock_ticks;
          ev              = EV_GRANTED;
        end else if (uid == UID_ADMIN) begin
          hold_timer_next = cfg.admin_hold_ticks;
          ev              = EV_ADMIN;
        end else begin
          hold_timer_next = cfg.invalid_hold_ticks;
          ev              = EV_INVALID;
        end
        entry_count_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      lock_state  <= 1'b0;
      open_timer  <= 16'd0;
      hold_timer  <= 16'd0;
    end else if (step) begin
      entry_count <= entry_count_next;
      lock_state  <= lock_state_next;
      open_timer  <= open_timer_next;
      hold_timer  <= hold_timer_next;
    end
  end

  // Stale slots are always overwritten before a full entry is compared.
  always_ff @(posedge clk) begin
    if (step && key_we) begin
      entry_keys[entry_count[IDX_W-1:0]] <= key_code;
    end
  end

  assign res.lock_open     = lock_state_next;
  assign res.event_res     = ev;
  assign res.user_id       = uid;
  assign res.entered_count = 3'(entry_count_next);
  assign res.holding       = (hold_timer_next != 16'd0);

  `KCL_ASSERT_NEXT(a_relock_clears, step && !action && lock_state && open_timer <= 16'd1, !lock_state && entry_count == '0, "lock did not close and clear on its last tick")
  `KCL_ASSERT_NEXT(a_hold_ignores_keys, step && action && hold_timer != 16'd0, $stable(entry_count) && $stable(lock_state) && $stable(open_timer), "key changed state during hold")
  `KCL_ASSERT_NOW(a_count_below_len, 1'b1, entry_count < CNT_W'(CODE_LEN), "entry buffer left full between beats")
  `KCL_ASSERT_NOW(a_uid_only_on_check, step && uid != UID_NONE, ev == EV_GRANTED || ev == EV_ADMIN, "user id reported without a match event")

endmodule

// ----- hw/rtl/keypad_code_lock.sv -----
// Top level of the keypad code lock: input and result registers around the update logic.
//
//   Channel   Direction  Handshake               Payload
//   in        sink       in_valid / in_stall     action, key_code
//   out       source     out_valid / out_stall   lock_open, event_res, user_id,
//                                                entered_count, holding
//   config    APB slave  psel/penable/pready     paddr, pwdata, prdata
//
// One beat per cycle while out_stall is low; an accepted beat goes through the input
// register, then the combinational state update, into the result register.
// The lock state advances when a beat moves from the input to the result register.
// Reset is synchronous and active high; it restores the default codes and timers.
// A stalled result holds its register; the input register still takes one more beat.
module keypad_code_lock (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       action,
  input  logic [3:0]                 key_code,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       lock_open,
  output logic [2:0]                 event_res,
  output logic [2:0]                 user_id,
  output logic [2:0]                 entered_count,
  output logic                       holding,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [kcl_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import kcl_pkg::*;

  kcl_cfg_t   cfg;
  kcl_res_t   core_res;
  kcl_res_t   res_r;

  logic       in_full;
  logic       action_r;
  logic [3:0] key_r;
  logic       in_take;
  logic       move;

  assign move     = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && !move;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      in_full   <= in_take || (in_full && !move);
      out_valid <= move || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      action_r <= action;
      key_r    <= key_code;
    end
    if (move) begin
      res_r <= core_res;
    end
  end

  kcl_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  kcl_core u_core (
    .clk      (clk),
    .rst      (rst),
    .step     (move),
    .action   (action_r),
    .key_code (key_r),
    .cfg      (cfg),
    .res      (core_res)
  );

  assign lock_open     = res_r.lock_open;
  assign event_res     = res_r.event_res;
  assign user_id       = res_r.user_id;
  assign entered_count = res_r.entered_count;
  assign holding       = res_r.holding;

endmodule
